// ===== rtl/source_address_flow_hash_steer_core_defines.svh =====
// Assertion macros for the source address flow hash steering core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SOURCE_ADDRESS_FLOW_HASH_STEER_CORE_DEFINES_SVH
`define SOURCE_ADDRESS_FLOW_HASH_STEER_CORE_DEFINES_SVH

// condition holds in the same cycle
`define SFH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define SFH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfh_pkg.sv =====
// Shared types, constants and the jhash final-mix helpers for the steering core.
// No dependencies.
`default_nettype none

package sfh_pkg;

  localparam int HASH_W     = 32;
  localparam int PROTO_W    = 8;
  localparam int BUCKET_W   = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CNT_WR_W   = 8;

  localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

  // jhash initval for a 12-byte key: golden constant plus length
  localparam logic [HASH_W-1:0] SEED_INIT = 32'hdeadbeef + 32'(3 << 2);

  // configuration register indexes
  typedef logic [CFG_IDX_W-1:0] sfh_cfg_idx_t;
  localparam sfh_cfg_idx_t CFG_HASH_NONCE   = 1'b0;
  localparam sfh_cfg_idx_t CFG_BUCKET_COUNT = 1'b1;

  // remainder pipeline: bits retired per stage
  localparam int MOD_STEP_BITS = 4;
  localparam int MOD_STAGES    = HASH_W / MOD_STEP_BITS;

  // per-word steering flags that ride along the pipeline
  typedef struct packed {
    logic drop;
    logic udp;
  } sfh_flags_t;

  // final mix: seven xor/subtract/rotate steps over a, b, c
  localparam int MIX_N      = 7;
  localparam int MIX_STEP_W = $clog2(MIX_N);

  typedef logic [1:0] sfh_sel_t;
  localparam sfh_sel_t SEL_A = 2'd0;
  localparam sfh_sel_t SEL_B = 2'd1;
  localparam sfh_sel_t SEL_C = 2'd2;

  typedef logic [2:0][HASH_W-1:0] sfh_abc_t;

  localparam sfh_sel_t MIX_DST [MIX_N] = '{SEL_C, SEL_A, SEL_B, SEL_C, SEL_A, SEL_B, SEL_C};
  localparam sfh_sel_t MIX_SRC [MIX_N] = '{SEL_B, SEL_C, SEL_A, SEL_B, SEL_C, SEL_A, SEL_B};
  localparam logic [4:0] MIX_ROT [MIX_N] = '{5'd14, 5'd11, 5'd25, 5'd16, 5'd4, 5'd14, 5'd24};

  // rotate left, amount 0..31
  function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] v,
                                              input logic [4:0] s);
    logic [2*HASH_W-1:0] t;
    t = {v, v} << s;
    return t[2*HASH_W-1:HASH_W];
  endfunction

  // one step of the final mix: x ^= y; x -= rotl(y, r)
  function automatic sfh_abc_t mix_step(input sfh_abc_t abc,
                                        input logic [MIX_STEP_W-1:0] step);
    sfh_abc_t   res;
    sfh_sel_t   dst;
    sfh_sel_t   src;
    res = abc;
    dst = MIX_DST[step];
    src = MIX_SRC[step];
    res[dst] = (abc[dst] ^ abc[src]) - rotl(abc[src], MIX_ROT[step]);
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sfh_if.sv =====
// Valid/ready channel interfaces for the steering core: header in, verdict out.
// Depends on sfh_pkg for field widths.
`default_nettype none

interface sfh_in_if;
  logic                          valid;
  logic                          ready;
  logic                          is_ipv4;
  logic [sfh_pkg::PROTO_W-1:0]   l4_proto;
  logic [sfh_pkg::HASH_W-1:0]    src_word0;
  logic [sfh_pkg::HASH_W-1:0]    src_word1;
  logic [sfh_pkg::HASH_W-1:0]    src_word2;
  logic [sfh_pkg::HASH_W-1:0]    src_word3;

  modport source (output valid, is_ipv4, l4_proto, src_word0, src_word1, src_word2,
                  src_word3, input ready);
  modport sink   (input valid, is_ipv4, l4_proto, src_word0, src_word1, src_word2,
                  src_word3, output ready);
endinterface

interface sfh_out_if;
  logic                          valid;
  logic                          ready;
  logic                          verdict;
  logic                          target_table;
  logic [sfh_pkg::BUCKET_W-1:0]  bucket;

  modport source (output valid, verdict, target_table, bucket, input ready);
  modport sink   (input valid, verdict, target_table, bucket, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfh_hash.sv =====
// Hash pipeline: protocol classify, word sum, then one final-mix step per stage.
// Depends on sfh_pkg.
`default_nettype none

module sfh_hash (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        v_in,
  input  wire logic                        is_ipv4,
  input  wire logic [sfh_pkg::PROTO_W-1:0] l4_proto,
  input  wire logic [sfh_pkg::HASH_W-1:0]  src_word0,
  input  wire logic [sfh_pkg::HASH_W-1:0]  src_word1,
  input  wire logic [sfh_pkg::HASH_W-1:0]  src_word2,
  input  wire logic [sfh_pkg::HASH_W-1:0]  src_word3,
  input  wire logic [sfh_pkg::HASH_W-1:0]  seed,
  output logic                             v_out,
  output sfh_pkg::sfh_flags_t              flags_out,
  output logic [sfh_pkg::HASH_W-1:0]       hash_out
);

  localparam int N = sfh_pkg::MIX_N;

  // pre stage: flags and partial sums
  logic                            pre_v_r;
  sfh_pkg::sfh_flags_t             pre_flags_r;
  logic [sfh_pkg::HASH_W-1:0]      pre_s01_r;
  logic [sfh_pkg::HASH_W-1:0]      pre_s23_r;

  // mix stages: index 0 holds the seeded a/b/c, index k the value after step k
  logic [N:0]                      mix_v_r;
  sfh_pkg::sfh_flags_t             mix_flags_r [N+1];
  sfh_pkg::sfh_abc_t               mix_abc_r   [N+1];
  sfh_pkg::sfh_abc_t               mix_abc_nxt [N+1];

  sfh_pkg::sfh_flags_t             flags_in;
  logic [sfh_pkg::HASH_W-1:0]      w1_m;
  logic [sfh_pkg::HASH_W-1:0]      w2_m;
  logic [sfh_pkg::HASH_W-1:0]      w3_m;

  // classify protocol; IPv4 hashes only the first word
  always_comb begin
    flags_in.udp  = (l4_proto == sfh_pkg::PROTO_UDP);
    flags_in.drop = !((l4_proto == sfh_pkg::PROTO_TCP) ||
                      (l4_proto == sfh_pkg::PROTO_UDP));
    w1_m = is_ipv4 ? '0 : src_word1;
    w2_m = is_ipv4 ? '0 : src_word2;
    w3_m = is_ipv4 ? '0 : src_word3;
  end

  // seed a/b/c, then one mix step per stage
  always_comb begin
    mix_abc_nxt[0][sfh_pkg::SEL_A] = pre_s01_r + pre_s23_r + seed;
    mix_abc_nxt[0][sfh_pkg::SEL_B] = seed;
    mix_abc_nxt[0][sfh_pkg::SEL_C] = seed;
    for (int k = 1; k <= N; k++) begin
      mix_abc_nxt[k] = sfh_pkg::mix_step(mix_abc_r[k-1], sfh_pkg::MIX_STEP_W'(k - 1));
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
      mix_v_r <= '0;
    end else if (en) begin
      pre_v_r <= v_in;
      mix_v_r <= {mix_v_r[N-1:0], pre_v_r};
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      pre_flags_r    <= flags_in;
      pre_s01_r      <= src_word0 + w1_m;
      pre_s23_r      <= w2_m + w3_m;
      mix_flags_r[0] <= pre_flags_r;
      mix_abc_r[0]   <= mix_abc_nxt[0];
      for (int k = 1; k <= N; k++) begin
        mix_flags_r[k] <= mix_flags_r[k-1];
        mix_abc_r[k]   <= mix_abc_nxt[k];
      end
    end
  end

  assign v_out     = mix_v_r[N];
  assign flags_out = mix_flags_r[N];
  assign hash_out  = mix_abc_r[N][sfh_pkg::SEL_C];

endmodule

`default_nettype wire

// ===== rtl/sfh_mod.sv =====
// Pipelined restoring remainder: hash modulo bucket count, a few bits per stage.
// Depends on sfh_pkg.
`default_nettype none

module sfh_mod #(
  parameter int CNT_W = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       v_in,
  input  wire sfh_pkg::sfh_flags_t        flags_in,
  input  wire logic [sfh_pkg::HASH_W-1:0] hash_in,
  input  wire logic [CNT_W-1:0]           cnt,
  output logic                            v_out,
  output sfh_pkg::sfh_flags_t             flags_out,
  output logic [CNT_W-1:0]                rem_out
);

  localparam int ST   = sfh_pkg::MOD_STAGES;
  localparam int STEP = sfh_pkg::MOD_STEP_BITS;
  localparam int HW   = sfh_pkg::HASH_W;

  logic [ST-1:0]         v_r;
  sfh_pkg::sfh_flags_t   flags_r [ST];
  logic [HW-1:0]         dvd_r   [ST];
  logic [HW-1:0]         dvd_nxt [ST];
  logic [CNT_W-1:0]      rem_r   [ST];
  logic [CNT_W-1:0]      rem_nxt [ST];

  // each stage shifts in STEP dividend bits, subtracting the count when it fits
  always_comb begin
    logic [HW-1:0]    d;
    logic [CNT_W-1:0] r;
    logic [CNT_W:0]   t;
    for (int k = 0; k < ST; k++) begin
      if (k == 0) begin
        d = hash_in;
        r = '0;
      end else begin
        d = dvd_r[k-1];
        r = rem_r[k-1];
      end
      for (int j = 0; j < STEP; j++) begin
        t = {r, d[HW-1]};
        d = d << 1;
        if (t >= {1'b0, cnt}) begin
          t = t - {1'b0, cnt};
        end
        r = t[CNT_W-1:0];
      end
      dvd_nxt[k] = d;
      rem_nxt[k] = r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ST-2:0], v_in};
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      flags_r[0] <= flags_in;
      dvd_r[0]   <= dvd_nxt[0];
      rem_r[0]   <= rem_nxt[0];
      for (int k = 1; k < ST; k++) begin
        flags_r[k] <= flags_r[k-1];
        dvd_r[k]   <= dvd_nxt[k];
        rem_r[k]   <= rem_nxt[k];
      end
    end
  end

  assign v_out     = v_r[ST-1];
  assign flags_out = flags_r[ST-1];
  assign rem_out   = rem_r[ST-1];

endmodule

`default_nettype wire

// ===== rtl/source_address_flow_hash_steer_core.sv =====
// 18 register stages. Throughput: one word per cycle while the skid entry is free;
// 1 pre stage, 8 hash stages (seed, then 7 mix steps), 8 remainder stages
// (4 quotient bits each) and an output register with a skid entry.
// Reset (rst_n, synchronous, active low) empties the pipeline and output, sets the
// hash nonce to 0 and the bucket count to 0, which selects MAX_BUCKETS buckets.
// Depends on sfh_pkg, sfh_if, sfh_hash, sfh_mod and the defines header.
`default_nettype none
`include "source_address_flow_hash_steer_core_defines.svh"

module source_address_flow_hash_steer_core #(
  parameter int MAX_BUCKETS = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  sfh_in_if.sink                              in_ch,
  sfh_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire sfh_pkg::sfh_cfg_idx_t          cfg_index,
  input  wire logic [sfh_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_BUCKETS + 1);

  typedef struct packed {
    logic                          verdict;
    logic                          table_sel;
    logic [sfh_pkg::BUCKET_W-1:0]  bucket;
  } sfh_res_t;

  // configuration: nonce is kept pre-added to the jhash initval
  logic [sfh_pkg::HASH_W-1:0]   seed_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [sfh_pkg::CNT_WR_W-1:0] cnt_wr;
  logic [CNT_W-1:0]             cnt_sat;
  logic [CNT_W-1:0]             cnt_eff;

  // pipeline hookup
  logic                         en;
  logic                         h_v;
  sfh_pkg::sfh_flags_t          h_flags;
  logic [sfh_pkg::HASH_W-1:0]   h_hash;
  logic                         m_v;
  sfh_pkg::sfh_flags_t          m_flags;
  logic [CNT_W-1:0]             m_rem;

  // output register and skid entry
  logic                         out_valid_r;
  sfh_res_t                     out_res_r;
  logic                         skid_valid_r;
  sfh_res_t                     skid_res_r;
  sfh_res_t                     last_res;
  logic                         take;

  // bucket count write saturates; zero selects the maximum
  assign cnt_wr  = cfg_wdata[sfh_pkg::CNT_WR_W-1:0];
  assign cnt_sat = (32'(cnt_wr) > 32'(MAX_BUCKETS)) ? CNT_W'(MAX_BUCKETS) : CNT_W'(cnt_wr);
  assign cnt_eff = (cnt_r == '0) ? CNT_W'(MAX_BUCKETS) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= sfh_pkg::SEED_INIT;
      cnt_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfh_pkg::CFG_HASH_NONCE:   seed_r <= cfg_wdata + sfh_pkg::SEED_INIT;
        sfh_pkg::CFG_BUCKET_COUNT: cnt_r  <= cnt_sat;
        default: ;
      endcase
    end
  end

  // whole pipeline moves while the skid entry is free
  assign en           = !skid_valid_r;
  assign in_ch.ready  = en;

  sfh_hash u_hash (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .v_in        (in_ch.valid),
    .is_ipv4     (in_ch.is_ipv4),
    .l4_proto    (in_ch.l4_proto),
    .src_word0   (in_ch.src_word0),
    .src_word1   (in_ch.src_word1),
    .src_word2   (in_ch.src_word2),
    .src_word3   (in_ch.src_word3),
    .seed        (seed_r),
    .v_out       (h_v),
    .flags_out   (h_flags),
    .hash_out    (h_hash)
  );

  sfh_mod #(.CNT_W(CNT_W)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .v_in      (h_v),
    .flags_in  (h_flags),
    .hash_in   (h_hash),
    .cnt       (cnt_eff),
    .v_out     (m_v),
    .flags_out (m_flags),
    .rem_out   (m_rem)
  );

  // format result; a dropped word carries table 0 and bucket 0
  always_comb begin
    last_res.verdict   = m_flags.drop;
    last_res.table_sel = m_flags.udp;
    last_res.bucket    = m_flags.drop ? '0 : sfh_pkg::BUCKET_W'(m_rem);
  end

  assign take = en && m_v;

  // output control: skid catches a word leaving the pipeline while output is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r  <= skid_valid_r || take;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      skid_valid_r <= 1'b1;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_res_r <= skid_valid_r ? skid_res_r : last_res;
    end else if (take) begin
      skid_res_r <= last_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.verdict      = out_res_r.verdict;
  assign out_ch.target_table = out_res_r.table_sel;
  assign out_ch.bucket       = out_res_r.bucket;

  // checks
  `SFH_ASSERT_SAME(a_skid_holds_input, skid_valid_r, out_valid_r && !in_ch.ready,
                   "skid full with output empty or input open")
  `SFH_ASSERT_NEXT(a_skid_catches, out_valid_r && !out_ch.ready && take, skid_valid_r,
                   "word leaving pipeline not caught by skid")
  `SFH_ASSERT_SAME(a_drop_clean, out_valid_r && out_res_r.verdict,
                   (out_res_r.table_sel == 1'b0) && (out_res_r.bucket == '0),
                   "dropped word with nonzero table or bucket")
  `SFH_ASSERT_SAME(a_cnt_nonzero, 1'b1,
                   (cnt_eff != '0) && (32'(cnt_eff) <= 32'(MAX_BUCKETS)),
                   "effective bucket count out of range")

endmodule

`default_nettype wire

// ===== test/source_address_flow_hash_steer_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for source_address_flow_hash_steer_core: source address jhash steering.
// Needs sfh_pkg, sfh_in_if / sfh_out_if and the core; self-checking against an
// in-bench hash predictor, with random idling on both channels.

module source_address_flow_hash_steer_core_tb;

  localparam int MAX_BUCKETS     = 128;
  localparam int DIR_ROWS        = 22;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 42;
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 40;

  localparam logic [31:0] JHASH_GOLDEN = 32'hdeadbeef;
  localparam logic [31:0] KEY_BYTES    = 32'd12;

  // steered protocols
  localparam logic [7:0] PROTO_TCP = sfh_pkg::PROTO_TCP;
  localparam logic [7:0] PROTO_UDP = sfh_pkg::PROTO_UDP;

  // protocols outside the steered pair
  localparam logic [7:0] PROTO_HOPOPT = 8'd0;
  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_RSVD   = 8'hff;

  typedef struct packed {
    logic        is_ipv4;
    logic [7:0]  l4_proto;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } pkt_hdr_t;

  typedef struct packed {
    logic       verdict;
    logic       target_table;
    logic [6:0] bucket;
  } steer_t;

  typedef struct packed {
    pkt_hdr_t hdr;
    logic     typed;
    steer_t   want;
  } dir_row_t;

  localparam steer_t NO_WORD   = 9'b0_0_0000000;
  localparam steer_t DROP_WORD = 9'b1_0_0000000;

  // directed headers: field extremes, both protocols, drops around the steered codes
  localparam dir_row_t HDR_TABLE [DIR_ROWS] = '{
    {1'b1, PROTO_TCP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WORD},
    {1'b1, PROTO_UDP, 32'hffffffff, 32'h0, 32'h0, 32'h0, 1'b0, NO_WORD},
    // IPv4 must ignore the upper words
    {1'b1, PROTO_TCP, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
     1'b0, NO_WORD},
    {1'b0, PROTO_TCP, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
     1'b0, NO_WORD},
    {1'b0, PROTO_UDP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WORD},
    // word sum wraps to zero
    {1'b0, PROTO_UDP, 32'hffffffff, 32'h00000001, 32'h0, 32'h0, 1'b0, NO_WORD},
    {1'b0, PROTO_TCP, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
     1'b0, NO_WORD},
    {1'b1, PROTO_UDP, 32'hc0a80001, 32'hdeadbeef, 32'h12345678, 32'h9abcdef0,
     1'b0, NO_WORD},
    {1'b0, PROTO_UDP, 32'h20010db8, 32'h0, 32'h0, 32'h00000001, 1'b0, NO_WORD},
    {1'b1, PROTO_HOPOPT, 32'h0a000001, 32'h0, 32'h0, 32'h0, 1'b1, DROP_WORD},
    {1'b0, PROTO_RSVD, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
     1'b1, DROP_WORD},
    {1'b1, PROTO_TCP - 8'd1, 32'h01020304, 32'h0, 32'h0, 32'h0, 1'b1, DROP_WORD},
    {1'b1, PROTO_TCP + 8'd1, 32'h01020304, 32'h0, 32'h0, 32'h0, 1'b1, DROP_WORD},
    {1'b0, PROTO_UDP - 8'd1, 32'hfe800000, 32'h0, 32'h0, 32'h1, 1'b1, DROP_WORD},
    {1'b0, PROTO_UDP + 8'd1, 32'hfe800000, 32'h0, 32'h0, 32'h1, 1'b1, DROP_WORD},
    {1'b1, PROTO_TCP | 8'h80, 32'h7f000001, 32'h0, 32'h0, 32'h0, 1'b1, DROP_WORD},
    {1'b0, PROTO_UDP | 8'h80, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, DROP_WORD},
    {1'b1, PROTO_TCP, 32'h80000000, 32'h0, 32'h0, 32'h0, 1'b0, NO_WORD},
    {1'b0, PROTO_TCP, 32'h00000001, 32'h0, 32'h0, 32'h0, 1'b0, NO_WORD},
    {1'b1, PROTO_UDP, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 1'b0, NO_WORD},
    {1'b0, PROTO_ICMP, 32'h20010db8, 32'h1, 32'h2, 32'h3, 1'b1, DROP_WORD},
    {1'b0, PROTO_UDP, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
     1'b0, NO_WORD}
  };

  // register settings per phase; some entries get replaced by random values
  localparam logic [31:0] NONCE_WR [PHASES] = '{
    32'hffffffff, 32'h0, 32'h1, 32'h80000000, 32'hffffffff, 32'h0,
    32'h12345678, 32'h0, 32'hfffffffe, 32'h1, 32'h0, 32'hffffffff
  };
  localparam logic [31:0] COUNT_WR [PHASES] = '{
    32'd1, 32'd2, 32'd127, 32'd128, 32'd255, 32'h1ff,
    32'h105, 32'd0, 32'd3, 32'd64, 32'd0, 32'd0
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  sfh_pkg::sfh_cfg_idx_t cfg_index;
  logic [31:0]           cfg_wdata;
  logic                  sink_ready = 1'b0;

  sfh_in_if  in_ch ();
  sfh_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  source_address_flow_hash_steer_core #(
    .MAX_BUCKETS(MAX_BUCKETS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // register copies used by the predictor
  logic [31:0] nonce_mirror = 32'h0;
  logic [7:0]  count_mirror = 8'h0;

  steer_t      pending_verdicts [$];
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;
  int unsigned hold;
  logic        gaps_on  = 1'b1;
  logic        stall_on = 1'b1;
  steer_t      want_w;
  steer_t      got_w;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // expected steering word for one header under the current register copies
  function automatic steer_t steer_verdict_of(input pkt_hdr_t h);
    logic [31:0] seed;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    int unsigned n;
    steer_t      r;
    r = NO_WORD;
    if (h.l4_proto != PROTO_TCP && h.l4_proto != PROTO_UDP) return DROP_WORD;
    r.target_table = (h.l4_proto == PROTO_UDP);
    seed = nonce_mirror + JHASH_GOLDEN + KEY_BYTES;
    a = seed + (h.is_ipv4 ? h.w0 : h.w0 + h.w1 + h.w2 + h.w3);
    b = seed;
    c = seed;
    // jhash final mix
    c = (c ^ b) - rol32(b, 14);
    a = (a ^ c) - rol32(c, 11);
    b = (b ^ a) - rol32(a, 25);
    c = (c ^ b) - rol32(b, 16);
    a = (a ^ c) - rol32(c, 4);
    b = (b ^ a) - rol32(a, 14);
    c = (c ^ b) - rol32(b, 24);
    n = (count_mirror == 8'd0) ? MAX_BUCKETS : count_mirror;
    r.bucket = 7'(c % n);
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // random word; zero and all-ones turn up often enough to matter
  function automatic logic [31:0] addr_word();
    int unsigned k;
    k = $urandom_range(0, 15);
    if (k == 0) return 32'h0;
    if (k == 1) return 32'hffffffff;
    return $urandom;
  endfunction

  // mostly steered traffic, the rest any protocol
  function automatic pkt_hdr_t rand_hdr();
    pkt_hdr_t    h;
    int unsigned r;
    r = $urandom_range(0, 9);
    h.is_ipv4  = 1'($urandom_range(0, 1));
    h.l4_proto = (r < 4) ? PROTO_TCP : (r < 8) ? PROTO_UDP : 8'($urandom_range(0, 255));
    h.w0 = addr_word();
    h.w1 = addr_word();
    h.w2 = addr_word();
    h.w3 = addr_word();
    return h;
  endfunction

  task automatic send_hdr(input pkt_hdr_t h, input logic typed, input steer_t want);
    int unsigned gap;
    gap = gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.is_ipv4   <= h.is_ipv4;
    in_ch.l4_proto  <= h.l4_proto;
    in_ch.src_word0 <= h.w0;
    in_ch.src_word1 <= h.w1;
    in_ch.src_word2 <= h.w2;
    in_ch.src_word3 <= h.w3;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_verdicts.push_back(typed ? want : steer_verdict_of(h));
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input sfh_pkg::sfh_cfg_idx_t idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      sfh_pkg::CFG_HASH_NONCE: nonce_mirror = data;
      sfh_pkg::CFG_BUCKET_COUNT: begin
        count_mirror = (data[7:0] > MAX_BUCKETS) ? 8'(MAX_BUCKETS) : data[7:0];
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, switched off in some phases
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      hold = stall_on ? idle_len() : 0;
      if (hold == 0) begin
        sink_ready <= 1'b1;
      end else begin
        sink_ready <= 1'b0;
        stall_left <= hold - 1;
      end
    end
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got_w = {out_ch.verdict, out_ch.target_table, out_ch.bucket};
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected word: verdict %b table %b bucket %0d",
                   got_w.verdict, got_w.target_table, got_w.bucket);
      end else begin
        want_w = pending_verdicts.pop_front();
        if (got_w.verdict !== want_w.verdict || got_w.target_table !== want_w.target_table ||
            got_w.bucket !== want_w.bucket) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected verdict %b table %b bucket %0d, got %b %b %0d",
                     want_w.verdict, want_w.target_table, want_w.bucket,
                     got_w.verdict, got_w.target_table, got_w.bucket);
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned i;
    logic [31:0] nonce_wr;
    logic [31:0] count_wr;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= sfh_pkg::CFG_HASH_NONCE;
    cfg_wdata       <= 32'h0;
    in_ch.valid     <= 1'b0;
    in_ch.is_ipv4   <= 1'b0;
    in_ch.l4_proto  <= 8'h0;
    in_ch.src_word0 <= 32'h0;
    in_ch.src_word1 <= 32'h0;
    in_ch.src_word2 <= 32'h0;
    in_ch.src_word3 <= 32'h0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed headers under reset register values
    for (i = 0; i < DIR_ROWS; i++)
      send_hdr(HDR_TABLE[i].hdr, HDR_TABLE[i].typed, HDR_TABLE[i].want);
    in_ch.valid <= 1'b0;

    // random phases, registers rewritten while idle
    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      nonce_wr = (p % 3 == 2) ? $urandom : NONCE_WR[p];
      count_wr = (p >= 10) ? {16'($urandom_range(0, 16'hffff)), 16'($urandom_range(0, 255))}
                           : COUNT_WR[p];
      write_reg(sfh_pkg::CFG_HASH_NONCE, nonce_wr);
      write_reg(sfh_pkg::CFG_BUCKET_COUNT, count_wr);
      cfg_we   <= 1'b0;
      gaps_on   = (p % 3 != 0);
      stall_on <= (p % 4 != 0);
      for (i = 0; i < ITEMS_PER_PHASE; i++) send_hdr(rand_hdr(), 1'b0, NO_WORD);
      in_ch.valid <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_verdicts.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
